// ----- sv/fed_pkg.sv -----
// Shared types and constants of the frame-wise Euclidean distance scorer.
package fed_pkg;

    // Field and datapath widths
    localparam int COEF_W   = 16;
    localparam int DIFF_W   = COEF_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int SUM_W    = 38;
    localparam int DIST_W   = 19;
    localparam int TOTAL_W  = 29;
    localparam int ZD_W     = 29;
    localparam int SCORE_W  = 16;
    localparam int HUND_W   = 15;
    localparam int PROD_W   = TOTAL_W + HUND_W;
    localparam int STEP_W   = 6;

    // Iteration counts of the shared step counter
    localparam int ROOT_STEPS = DIST_W;
    localparam int DIV_STEPS  = PROD_W;

    // Score constants, Q8.8 percent
    localparam logic [HUND_W-1:0]  HUNDRED_Q88 = 15'd25600;
    localparam logic [SCORE_W-1:0] SCORE_MIN   = 16'h8000;
    localparam logic [PROD_W-1:0]  SCORE_SAT   = 44'd58368;
    localparam logic [ZD_W-1:0]    ZD_RESET    = 29'd256;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_ROOT_LOAD,
        S_ROOT,
        S_TOTAL,
        S_SCALE,
        S_DIVIDE,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic in_load;
        logic sq_load;
        logic acc_load;
        logic root_load;
        logic root_step;
        logic total_load;
        logic scale_load;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic frame_done;
        logic seq_end;
        logic step_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- sv/fed_ctrl.sv -----
// Sequencing state machine of the frame-wise Euclidean distance scorer.
module fed_ctrl import fed_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SQUARE;
            end
            S_SQUARE: begin
                n_state = S_ACCUM;
            end
            S_ACCUM: begin
                n_state = i_sts.frame_done ? S_ROOT_LOAD : S_IDLE;
            end
            S_ROOT_LOAD: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (i_sts.step_last) n_state = S_TOTAL;
            end
            S_TOTAL: begin
                n_state = i_sts.seq_end ? S_SCALE : S_EMIT;
            end
            S_SCALE: begin
                n_state = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (i_sts.step_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.in_load = i_in_valid;
            end
            S_SQUARE:    o_cmd.sq_load    = 1'b1;
            S_ACCUM:     o_cmd.acc_load   = 1'b1;
            S_ROOT_LOAD: o_cmd.root_load  = 1'b1;
            S_ROOT:      o_cmd.root_step  = 1'b1;
            S_TOTAL:     o_cmd.total_load = 1'b1;
            S_SCALE:     o_cmd.scale_load = 1'b1;
            S_DIVIDE:    o_cmd.div_step   = 1'b1;
            S_EMIT:      o_cmd.out_load   = i_sts.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Iterative phases stay put until the step counter runs out
    a_root_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) && !i_sts.step_last |=> (r_state == S_ROOT))
        else $error("square root left early");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE) && !i_sts.step_last |=> (r_state == S_DIVIDE))
        else $error("divide left early");

    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && !i_sts.out_free |=> (r_state == S_EMIT))
        else $error("result dropped while output busy");

endmodule

// ----- sv/fed_dp.sv -----
// Datapath: difference squaring, frame sum, iterative root and divide, output register.
module fed_dp import fed_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [ZD_W-1:0]           i_cfg_wr_data,
    input  logic signed [COEF_W-1:0]  i_target_coef,
    input  logic signed [COEF_W-1:0]  i_result_coef,
    input  logic                      i_frame_end,
    input  logic                      i_sequence_end,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [DIST_W-1:0]         o_frame_distance,
    output logic [TOTAL_W-1:0]        o_total_difference,
    output logic signed [SCORE_W-1:0] o_score,
    output logic                      o_is_final
);

    // Control and state registers
    logic [ZD_W-1:0]    r_zd;
    logic [SUM_W-1:0]   r_sum;
    logic [TOTAL_W-1:0] r_total;
    logic               r_out_valid;

    // Working registers
    logic [DIFF_W-1:0]  r_ad;
    logic               r_frame_end;
    logic               r_seq_end;
    logic [SQ_W-1:0]    r_sq;
    logic [SUM_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_res;
    logic [STEP_W-1:0]  r_step;
    logic [ZD_W-1:0]    r_div_rem;
    logic [PROD_W-1:0]  r_quot;

    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_ad;
    logic [SUM_W:0]           w_sum_add;
    logic [SUM_W-1:0]         n_sum;
    logic [TOTAL_W:0]         w_total_add;
    logic [TOTAL_W-1:0]       n_total;
    logic [SUM_W-1:0]         w_bit;
    logic [SUM_W:0]           w_trial;
    logic                     w_take;
    logic [ZD_W-1:0]          w_divisor;
    logic [ZD_W:0]            w_div_shift;
    logic                     w_div_take;
    logic [SCORE_W:0]         w_score_raw;
    logic [SCORE_W-1:0]       w_score;

    // Absolute difference of the incoming pair
    assign w_diff = DIFF_W'(i_target_coef) - DIFF_W'(i_result_coef);
    assign w_ad   = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);

    // Saturating frame sum
    assign w_sum_add = {1'b0, r_sum} + (SUM_W+1)'(r_sq);
    assign n_sum     = w_sum_add[SUM_W] ? {SUM_W{1'b1}} : w_sum_add[SUM_W-1:0];

    // Saturating running total
    assign w_total_add = {1'b0, r_total} + (TOTAL_W+1)'(r_res[DIST_W-1:0]);
    assign n_total     = w_total_add[TOTAL_W] ? {TOTAL_W{1'b1}} : w_total_add[TOTAL_W-1:0];

    // One root digit per step: trial bit is four to the step index
    assign w_bit   = SUM_W'(1) << {r_step[STEP_W-2:0], 1'b0};
    assign w_trial = {1'b0, r_res} + {1'b0, w_bit};
    assign w_take  = ({1'b0, r_rem} >= w_trial);

    // One quotient bit per step, zero normalizer treated as one
    assign w_divisor   = (r_zd == '0) ? ZD_W'(1) : r_zd;
    assign w_div_shift = {r_div_rem, r_quot[PROD_W-1]};
    assign w_div_take  = (w_div_shift >= {1'b0, w_divisor});

    // Score from the quotient, saturated low
    assign w_score_raw = (SCORE_W+1)'(HUNDRED_Q88) - {1'b0, r_quot[SCORE_W-1:0]};
    assign w_score     = (r_quot > SCORE_SAT) ? SCORE_MIN : w_score_raw[SCORE_W-1:0];

    // Register, sums and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zd        <= ZD_RESET;
            r_sum       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_zd <= i_cfg_wr_data;
            if (i_cmd.acc_load) r_sum <= n_sum;
            if (i_cmd.total_load) r_total <= n_total;
            if (i_cmd.out_load) begin
                r_sum <= '0;
                if (r_seq_end) r_total <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_ad        <= w_ad;
            r_frame_end <= i_frame_end;
            r_seq_end   <= i_sequence_end;
        end
        if (i_cmd.sq_load) r_sq <= r_ad * r_ad;
        if (i_cmd.root_load) begin
            r_rem  <= r_sum;
            r_res  <= '0;
            r_step <= STEP_W'(ROOT_STEPS - 1);
        end else if (i_cmd.root_step) begin
            if (w_take) begin
                r_rem <= r_rem - w_trial[SUM_W-1:0];
                r_res <= (r_res >> 1) + w_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.scale_load) begin
            r_quot    <= PROD_W'(r_total) * PROD_W'(HUNDRED_Q88);
            r_div_rem <= '0;
            r_step    <= STEP_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            if (w_div_take) begin
                r_div_rem <= ZD_W'(w_div_shift - {1'b0, w_divisor});
            end else begin
                r_div_rem <= w_div_shift[ZD_W-1:0];
            end
            r_quot <= {r_quot[PROD_W-2:0], w_div_take};
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.out_load) begin
            o_frame_distance   <= r_res[DIST_W-1:0];
            o_total_difference <= r_total;
            o_score            <= r_seq_end ? w_score : '0;
            o_is_final         <= r_seq_end;
        end
    end

    // Status
    assign o_sts.frame_done = r_frame_end | r_seq_end;
    assign o_sts.seq_end    = r_seq_end;
    assign o_sts.step_last  = (r_step == '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_sum == '0))
        else $error("frame sum not cleared after result");

    a_total_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_seq_end |=> (r_total == '0))
        else $error("running total not cleared at sequence end");

endmodule

// ----- sv/framewise_euclidean_distance_score.sv -----
// Top level of the frame-wise Euclidean distance scorer.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_ready    | target_coef, result_coef, frame_end, seq_end
//  output   | o_out_valid / i_out_ready  | frame_distance, total_difference, score, final
//  config   | i_cfg_wr_en                | i_cfg_wr_data (zero_difference)
//
// A coefficient pair passes through accept, square and accumulate.
// A frame end adds root load, 19 square-root steps, total and emit.
// A sequence end adds a scale multiply and 44 restoring-divide steps.
// Emit waits while the output register still holds an untaken transaction.
// Reset is synchronous; there is no clearing pass.
module framewise_euclidean_distance_score import fed_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [ZD_W-1:0]           i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [COEF_W-1:0]  i_target_coef,
    input  logic signed [COEF_W-1:0]  i_result_coef,
    input  logic                      i_frame_end,
    input  logic                      i_sequence_end,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [DIST_W-1:0]         o_frame_distance,
    output logic [TOTAL_W-1:0]        o_total_difference,
    output logic signed [SCORE_W-1:0] o_score,
    output logic                      o_is_final
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    fed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and output register
    fed_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_target_coef      (i_target_coef),
        .i_result_coef      (i_result_coef),
        .i_frame_end        (i_frame_end),
        .i_sequence_end     (i_sequence_end),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_frame_distance   (o_frame_distance),
        .o_total_difference (o_total_difference),
        .o_score            (o_score),
        .o_is_final         (o_is_final)
    );

endmodule
